// ===== src/sha1md_pkg.sv =====
package sha1md_pkg;

  localparam int NUM_WORDS   = 5;
  localparam int BLOCK_BITS  = 512;
  localparam int ROUNDS      = 80;
  localparam int QUEUE_DEPTH = 4;

  // initial chaining values h0..h4
  localparam logic [31:0] INIT_H0 = 32'h67452301;
  localparam logic [31:0] INIT_H1 = 32'hEFCDAB89;
  localparam logic [31:0] INIT_H2 = 32'h98BADCFE;
  localparam logic [31:0] INIT_H3 = 32'h10325476;
  localparam logic [31:0] INIT_H4 = 32'hC3D2E1F0;

  // round constants, one per group of twenty rounds
  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_P2  = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'(NUM_WORDS - 1);

  // queued item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  // sequencer to compression unit
  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       start;
    logic       restart;
  } cmp_ctl_t;

endpackage

// ===== src/sha1md_if.sv =====
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source(output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  modport source(output valid, digest_word, word_number, last_word, input ready);
  modport sink(input valid, digest_word, word_number, last_word, output ready);
endinterface

// ===== src/sha1md_front.sv =====
module sha1md_front #(
  parameter int QueueDepth = sha1md_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  sha1md_in_if.sink         msg,
  output sha1md_pkg::item_t q_item,
  output logic              q_valid,
  input  logic              q_ready
);
  import sha1md_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t          queue_mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic           push;
  logic           pop;

  // items with neither a byte nor an end carry no work and are dropped
  assign msg.ready = (fill != CntW'(QueueDepth));
  assign push      = msg.valid && msg.ready && (msg.byte_present || msg.end_of_message);
  assign q_valid   = (fill != '0);
  assign pop       = q_valid && q_ready;
  assign q_item    = queue_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= '{data_byte:      msg.data_byte,
                             byte_present:   msg.byte_present,
                             end_of_message: msg.end_of_message};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/sha1md_compress.sv =====
module sha1md_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1md_pkg::cmp_ctl_t ctl,
  output logic                 done,
  output logic [4:0][31:0]     chain
);
  import sha1md_pkg::*;

  logic [BLOCK_BITS-1:0] blk;
  logic [31:0] a, b, c, d, e;
  logic [6:0]  t;
  logic        running;
  logic        fin;
  logic [31:0] wt;
  logic [31:0] wx;
  logic [31:0] wnew;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] sum;

  // block buffer doubles as the message schedule window, w[t] at the top
  assign wt   = blk[511:480];
  assign wx   = blk[511:480] ^ blk[447:416] ^ blk[255:224] ^ blk[95:64];
  assign wnew = {wx[30:0], wx[31]};

  // round function and constant by round group
  always_comb begin
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_CH;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
      k = K_P1;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_MAJ;
    end else begin
      f = b ^ c ^ d;
      k = K_P2;
    end
  end

  assign sum  = {a[26:0], a[31:27]} + f + e + k + wt;
  assign done = fin;

  // byte shift in, schedule shift during rounds
  always_ff @(posedge clk) begin
    if (ctl.load_byte) begin
      blk <= {blk[BLOCK_BITS-9:0], ctl.byte_val};
    end else if (running) begin
      blk <= {blk[BLOCK_BITS-33:0], wnew};
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (running) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= sum;
    end
  end

  // round counter and run control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      t       <= '0;
    end else begin
      fin <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        t       <= '0;
      end else if (running) begin
        t <= t + 1'b1;
        if (t == 7'(ROUNDS - 1)) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
    end
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      chain <= {INIT_H4, INIT_H3, INIT_H2, INIT_H1, INIT_H0};
    end else if (fin) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

endmodule

// ===== src/sha1md_back.sv =====
module sha1md_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sha1md_pkg::item_t     q_item,
  input  logic                  q_valid,
  output logic                  q_ready,
  output sha1md_pkg::cmp_ctl_t  ctl,
  input  logic                  done,
  input  logic [4:0][31:0]      chain,
  sha1md_out_if.source          digest
);
  import sha1md_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_PAD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]  state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic [60:0] nbytes, nbytes_next;
  logic        padding, padding_next;
  logic        pad_started, pad_started_next;
  logic        in_len, in_len_next;
  logic        len_done, len_done_next;
  logic [2:0]  widx, widx_next;
  logic        out_valid, out_valid_next;
  logic [31:0] out_word, out_word_next;
  logic [2:0]  out_num, out_num_next;
  logic        out_last, out_last_next;
  logic [63:0] bitlen;

  assign bitlen  = {nbytes, 3'b000};
  assign q_ready = (state == S_IDLE);

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_number = out_num;
  assign digest.last_word   = out_last;

  // sequencer: absorb bytes, pad, wait on compression, emit digest
  always_comb begin
    ctl              = '0;
    state_next       = state;
    cnt_next         = cnt;
    nbytes_next      = nbytes;
    padding_next     = padding;
    pad_started_next = pad_started;
    in_len_next      = in_len;
    len_done_next    = len_done;
    widx_next        = widx;
    out_valid_next   = out_valid && !digest.ready;
    out_word_next    = out_word;
    out_num_next     = out_num;
    out_last_next    = out_last;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.byte_present) begin
            ctl.load_byte = 1'b1;
            ctl.byte_val  = q_item.data_byte;
            cnt_next      = cnt + 1'b1;
            nbytes_next   = nbytes + 1'b1;
            if (cnt == LAST_BYTE) begin
              ctl.start  = 1'b1;
              state_next = S_WAIT;
            end
          end
          if (q_item.end_of_message) begin
            padding_next = 1'b1;
            if (!(q_item.byte_present && cnt == LAST_BYTE)) begin
              state_next = S_PAD;
            end
          end
        end
      end
      S_WAIT: begin
        if (done) begin
          if (len_done) begin
            state_next = S_EMIT;
            widx_next  = '0;
          end else if (padding) begin
            state_next = S_PAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PAD: begin
        ctl.load_byte = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (!pad_started) begin
          ctl.byte_val     = PAD_BYTE;
          pad_started_next = 1'b1;
        end else if (in_len || cnt == LEN_START) begin
          // length bytes, most significant first, at positions 56..63
          ctl.byte_val = bitlen[{~cnt[2:0], 3'b000} +: 8];
          in_len_next  = 1'b1;
          if (cnt == LAST_BYTE) begin
            len_done_next = 1'b1;
          end
        end else begin
          ctl.byte_val = '0;
        end
        if (cnt == LAST_BYTE) begin
          ctl.start  = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || digest.ready) begin
          out_valid_next = 1'b1;
          out_word_next  = chain[widx];
          out_num_next   = widx;
          out_last_next  = (widx == LAST_WORD);
          if (widx == LAST_WORD) begin
            // digest handed off: start a fresh message
            ctl.restart      = 1'b1;
            nbytes_next      = '0;
            cnt_next         = '0;
            padding_next     = 1'b0;
            pad_started_next = 1'b0;
            in_len_next      = 1'b0;
            len_done_next    = 1'b0;
            state_next       = S_IDLE;
          end else begin
            widx_next = widx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      nbytes      <= '0;
      padding     <= 1'b0;
      pad_started <= 1'b0;
      in_len      <= 1'b0;
      len_done    <= 1'b0;
      widx        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      nbytes      <= nbytes_next;
      padding     <= padding_next;
      pad_started <= pad_started_next;
      in_len      <= in_len_next;
      len_done    <= len_done_next;
      widx        <= widx_next;
      out_valid   <= out_valid_next;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_word <= out_word_next;
    out_num  <= out_num_next;
    out_last <= out_last_next;
  end

endmodule

// ===== src/sha1_message_digest.sv =====
// sha1 digest engine, one message byte per item
// a byte is written into the input queue, then shifted by the sequencer into the block buffer;
//   a byte that fills a 64-byte block starts a compression (80 rounds plus the chaining add)
// end item: padding at one byte a cycle (up to 72 bytes), one or two compressions, then
//   five digest words at one per cycle while ready; input waits in the queue during compression
// reset (synchronous, rst high) empties the queue and output, restores h0..h4, zeroes length
module sha1_message_digest #(
  parameter int QueueDepth = sha1md_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  sha1md_in_if.sink     msg,
  sha1md_out_if.source  digest
);
  import sha1md_pkg::*;

  item_t            q_item;
  logic             q_valid;
  logic             q_ready;
  cmp_ctl_t         ctl;
  logic             done;
  logic [4:0][31:0] chain;

  // front: accept and queue items
  sha1md_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_ready(q_ready)
  );

  // back: padding sequencer and output register
  sha1md_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .ctl    (ctl),
    .done   (done),
    .chain  (chain),
    .digest (digest)
  );

  // block buffer and round datapath
  sha1md_compress u_compress (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .done (done),
    .chain(chain)
  );

endmodule

// ===== src/sha1md_checker.sv =====
module sha1md_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_number,
  input logic        last_word
);
  import sha1md_pkg::*;

  logic [2:0] exp_num;

  // expected index of the next digest word
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_num <= '0;
    end else if (out_valid && out_ready) begin
      exp_num <= last_word ? 3'd0 : exp_num + 1'b1;
    end
  end

  a_num_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> word_number <= LAST_WORD)
    else $error("digest word index out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_number == LAST_WORD)))
    else $error("last_word does not match the final index");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> word_number == exp_num)
    else $error("digest words out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_number))
    else $error("stalled digest item changed");

endmodule

bind sha1_message_digest sha1md_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (digest.valid),
  .out_ready  (digest.ready),
  .digest_word(digest.digest_word),
  .word_number(digest.word_number),
  .last_word  (digest.last_word)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sha1md_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 400;
  localparam int TARGET_ITEMS  = 380;
  localparam int MIN_MESSAGES  = 12;

  // one expected digest word
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        is_last;
  } digest_word_t;

  logic clk;
  logic rst;

  sha1md_in_if  msg_if();
  sha1md_out_if dig_if();

  sha1_message_digest DUT (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (dig_if)
  );

  // items waiting to be sent and digest words waiting to arrive
  item_t        msg_items[$];
  digest_word_t digest_expect[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int counted_items  = 0;
  int message_count  = 0;

  // sender burst shaping and receiver stall pattern
  int burst_left = 1;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  // predicted hash state
  logic [31:0] chain_h [NUM_WORDS];
  logic [31:0] blk_w [16];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic restart_chain();
    chain_h[0] = INIT_H0;
    chain_h[1] = INIT_H1;
    chain_h[2] = INIT_H2;
    chain_h[3] = INIT_H3;
    chain_h[4] = INIT_H4;
    blk_fill   = '0;
    msg_bits   = '0;
  endtask

  // 80-round compression of the current block into the chaining words
  task automatic sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, s;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < ROUNDS; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
        w[t % 16] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_P1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_P2;
      end
      s = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = s;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
  endtask

  // pack one byte big-endian, compressing when the block fills
  task automatic pack_byte(logic [7:0] b);
    logic [3:0] idx;
    idx = blk_fill[5:2];
    if (blk_fill[1:0] == 2'd0) blk_w[idx] = '0;
    blk_w[idx] = blk_w[idx] | ({24'd0, b} << ((3 - blk_fill[1:0]) * 8));
    if (blk_fill == LAST_BYTE) begin
      sha1_compress();
      blk_fill = '0;
    end else begin
      blk_fill = blk_fill + 6'd1;
    end
  endtask

  // advance the predicted state by one accepted item
  task automatic absorb_item(item_t it);
    logic [63:0]  len;
    digest_word_t dw;
    if (it.byte_present) begin
      pack_byte(it.data_byte);
      msg_bits = msg_bits + 64'd8;
    end
    if (it.end_of_message) begin
      len = msg_bits;
      pack_byte(PAD_BYTE);
      while (blk_fill != LEN_START) pack_byte(8'h00);
      for (int q = 0; q < 8; q++) pack_byte(len[63 - 8 * q -: 8]);
      for (int q = 0; q < NUM_WORDS; q++) begin
        dw.word    = chain_h[q];
        dw.index   = 3'(q);
        dw.is_last = (3'(q) == LAST_WORD);
        digest_expect.push_back(dw);
      end
      restart_chain();
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic queue_item(logic [7:0] b, logic present, logic last);
    item_t it;
    it.data_byte      = b;
    it.byte_present   = present;
    it.end_of_message = last;
    msg_items.push_back(it);
    if (present || last) counted_items++;
  endtask

  // a message of random bytes with the odd ignored item mixed in
  task automatic queue_message(int len, bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
      queue_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) queue_item(8'($urandom), 1'b0, 1'b1);
    message_count++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // driver: predicts on acceptance, then offers the next pending item
  always @(posedge clk) begin
    if (rst) begin
      msg_if.valid <= 1'b0;
    end else begin
      if (msg_if.valid && msg_if.ready)
        absorb_item({msg_if.data_byte, msg_if.byte_present, msg_if.end_of_message});
      if (!msg_if.valid || msg_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          msg_if.valid <= 1'b0;
        end else if (msg_items.size() > 0) begin
          item_t nxt;
          nxt = msg_items.pop_front();
          msg_if.valid          <= 1'b1;
          msg_if.data_byte      <= nxt.data_byte;
          msg_if.byte_present   <= nxt.byte_present;
          msg_if.end_of_message <= nxt.end_of_message;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          msg_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each digest word and shapes the receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      dig_if.ready <= 1'b0;
    end else begin
      if (dig_if.valid && dig_if.ready) begin
        if (digest_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h index %0d",
                                    dig_if.digest_word, dig_if.word_number));
        end else begin
          digest_word_t exp_w;
          exp_w = digest_expect.pop_front();
          if (dig_if.digest_word !== exp_w.word)
            report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                      dig_if.digest_word, exp_w.word, exp_w.index));
          if (dig_if.word_number !== exp_w.index)
            report_mismatch($sformatf("word_number %0d, expected %0d",
                                      dig_if.word_number, exp_w.index));
          if (dig_if.last_word !== exp_w.is_last)
            report_mismatch($sformatf("last_word %b, expected %b (index %0d)",
                                      dig_if.last_word, exp_w.is_last, exp_w.index));
        end
      end
      // a new stall pattern is drawn each time stall_tick runs down
      if (stall_tick == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_tick = 40;
      end
      stall_tick--;
      case (stall_mode)
        0: dig_if.ready <= 1'b1;
        1: dig_if.ready <= 1'($urandom_range(0, 1));
        2: dig_if.ready <= ($urandom_range(0, 4) == 0);
        default: dig_if.ready <= stall_tick[0];
      endcase
    end
  end

  // stimulus and end of run
  initial begin
    int len;
    rst                   = 1'b1;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = 8'h00;
    msg_if.byte_present   = 1'b0;
    msg_if.end_of_message = 1'b0;
    dig_if.ready          = 1'b0;
    restart_chain();
    for (int i = 0; i < 16; i++) blk_w[i] = '0;

    // empty message, end with no byte
    queue_item(8'hFF, 1'b0, 1'b1);
    // "abc", end on the last byte
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1);
    // ignored item inside a message, then a separate end
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1);
    // single-byte messages back to back, extremes of the byte
    queue_item(8'hFF, 1'b1, 1'b1);
    queue_item(8'h00, 1'b1, 1'b1);
    queue_item(8'h80, 1'b1, 1'b1);
    // ignored item between messages, then empty message again
    queue_item(8'h5A, 1'b0, 1'b0);
    queue_item(8'hA5, 1'b0, 1'b1);

    // random messages, biased towards the padding boundaries
    while (counted_items < TARGET_ITEMS || message_count < MIN_MESSAGES) begin
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(0, 24);
      end
      queue_message(len, 1'($urandom_range(0, 1)));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (msg_items.size() != 0 || msg_if.valid || digest_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && digest_expect.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sha1_message_digest.f =====
src/sha1md_pkg.sv
src/sha1md_if.sv
src/sha1md_front.sv
src/sha1md_compress.sv
src/sha1md_back.sv
src/sha1_message_digest.sv
src/sha1md_checker.sv
dv/testbench.sv
